>>> rtl/core/cle_pkg.sv
package cle_pkg;

  // Line store geometry
  localparam int LINE_BYTES = 160;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int POS_W      = $clog2(LINE_BYTES + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Key codes
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_DEL   = 8'h7f;
  localparam logic [7:0] KEY_US    = 8'h5f;
  localparam logic [7:0] KEY_BELL  = 8'h07;
  localparam logic [7:0] KEY_CTRLC = 8'h03;
  localparam logic [7:0] KEY_LF    = 8'h0a;
  localparam logic [7:0] KEY_CR    = 8'h0d;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_QUERY = 8'h3f;
  localparam logic [7:0] KEY_EQUAL = 8'h3d;
  localparam logic [7:0] KEY_BANG  = 8'h21;

  // Input item kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result kinds
  localparam logic [2:0] OUT_ECHO     = 3'd0;
  localparam logic [2:0] OUT_REPRINT  = 3'd1;
  localparam logic [2:0] OUT_OVERFLOW = 3'd2;
  localparam logic [2:0] OUT_COMPLETE = 3'd3;
  localparam logic [2:0] OUT_READ     = 3'd4;

  // Classified commands handed from front to back
  typedef enum logic [2:0] {
    OP_ECHO,
    OP_LINE_END,
    OP_RUBOUT,
    OP_CANCEL,
    OP_OVERFLOW,
    OP_READ
  } cmd_op_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] key_code;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] line_length;
    logic       last;
  } out_item_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic [7:0] len;
  } cmd_t;

  // Accepted key set: alphanumerics, space, BS, LF, ? _ = !
  function automatic logic key_valid(input logic [7:0] k);
    key_valid = (k inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) ||
                (k == KEY_SPACE) || (k == KEY_BS) || (k == KEY_LF) ||
                (k == KEY_QUERY) || (k == KEY_US) || (k == KEY_EQUAL) ||
                (k == KEY_BANG);
  endfunction

endpackage

>>> rtl/core/console_line_editor.sv
// Channel   Handshake           Payload
// -------   ---------           -------
// input     push / full         item   (kind, key_code, read_index)
// result    empty / pop         result (out_kind, out_byte, line_length, last)
//
// A key or read is taken when push is high and full is low; its results leave
// one per cycle while pop keeps up, and a key gives 1 to 4 results (overflow
// gives 4). First result path: store read and command stage, queue, back end.
// Synchronous reset empties the line and the 4-entry command queue; no clearing pass.
// full counts the command in flight; with no pop the queue fills and full rises.
module console_line_editor (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  cle_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output cle_pkg::out_item_t result
);

  logic                       q_push;
  cle_pkg::cmd_t              q_wr_cmd;
  logic                       q_pop;
  cle_pkg::cmd_t              q_rd_cmd;
  logic                       q_not_empty;
  logic [cle_pkg::QCNT_W-1:0] q_count;

  cle_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_count (q_count),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  cle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_push),
    .wr_cmd    (q_wr_cmd),
    .rd        (q_pop),
    .rd_cmd    (q_rd_cmd),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  cle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_cmd       (q_rd_cmd),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

>>> rtl/core/cle_ram.sv
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/cle_front.sv
module cle_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  cle_pkg::in_item_t             item,
  input  logic [cle_pkg::QCNT_W-1:0]    q_count,
  output logic                          q_push,
  output cle_pkg::cmd_t                 q_cmd
);

  logic [cle_pkg::POS_W-1:0]  wp;
  logic [cle_pkg::POS_W-1:0]  wp_next;
  logic                       line_finished;
  logic                       line_finished_next;
  logic                       s1_valid;
  cle_pkg::cmd_t              s1_cmd;
  cle_pkg::cmd_t              cmd_next;
  logic                       s1_hit;
  logic                       hit_next;
  logic                       accept;
  logic [cle_pkg::POS_W-1:0]  wp_eff;
  logic [7:0]                 k;
  logic                       line_full;
  logic                       store_we;
  logic [7:0]                 rdata;
  logic [cle_pkg::POS_W-1:0]  len_full;

  // Hold room in the queue for the command in flight
  assign full   = ({1'b0, q_count} + (cle_pkg::QCNT_W + 1)'(s1_valid)) >=
                  (cle_pkg::QCNT_W + 1)'(cle_pkg::QUEUE_DEPTH);
  assign accept = push && !full;

  // Map the key and find the effective line position
  assign wp_eff    = line_finished ? '0 : wp;
  assign k         = (item.key_code == cle_pkg::KEY_CR)  ? cle_pkg::KEY_LF :
                     (item.key_code == cle_pkg::KEY_DEL) ? cle_pkg::KEY_BS :
                     item.key_code;
  assign line_full = wp_eff >= cle_pkg::POS_W'(cle_pkg::LINE_BYTES - 1);
  assign len_full  = wp_eff + 1'b1;

  // Classify the item and update the line state
  always_comb begin
    wp_next            = wp;
    line_finished_next = line_finished;
    store_we           = 1'b0;
    cmd_next.op        = cle_pkg::OP_ECHO;
    cmd_next.data      = k;
    cmd_next.len       = '0;
    hit_next           = cle_pkg::POS_W'(item.read_index) < wp;
    if (item.kind == cle_pkg::KIND_READ) begin
      cmd_next.op   = cle_pkg::OP_READ;
      cmd_next.data = '0;
    end else begin
      line_finished_next = 1'b0;
      wp_next            = wp_eff;
      if ((k == cle_pkg::KEY_CTRLC) || (line_full && (k != cle_pkg::KEY_LF))) begin
        cmd_next.op = line_full ? cle_pkg::OP_OVERFLOW : cle_pkg::OP_CANCEL;
        wp_next     = '0;
      end else if (!cle_pkg::key_valid(k)) begin
        cmd_next.data = cle_pkg::KEY_BELL;
      end else if (k == cle_pkg::KEY_BS) begin
        if (wp_eff == '0) begin
          cmd_next.data = cle_pkg::KEY_BELL;
        end else begin
          cmd_next.op = cle_pkg::OP_RUBOUT;
          wp_next     = wp_eff - 1'b1;
        end
      end else begin
        store_we = 1'b1;
        wp_next  = len_full;
        if (k == cle_pkg::KEY_LF) begin
          cmd_next.op        = cle_pkg::OP_LINE_END;
          cmd_next.len       = len_full[7:0];
          line_finished_next = 1'b1;
        end
      end
    end
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (cle_pkg::LINE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_we),
    .waddr (wp_eff[cle_pkg::ADDR_W-1:0]),
    .wdata (k),
    .raddr (item.read_index[cle_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Advance line state and the command stage
  always_ff @(posedge clk) begin
    if (rst) begin
      wp            <= '0;
      line_finished <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        wp            <= wp_next;
        line_finished <= line_finished_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd_next;
      s1_hit <= hit_next;
    end
  end

  // Merge read data into read commands
  always_comb begin
    q_cmd = s1_cmd;
    if (s1_cmd.op == cle_pkg::OP_READ) begin
      q_cmd.data = s1_hit ? rdata : '0;
    end
  end

  assign q_push = s1_valid;

endmodule

>>> rtl/core/cle_queue.sv
module cle_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  cle_pkg::cmd_t              wr_cmd,
  input  logic                       rd,
  output cle_pkg::cmd_t              rd_cmd,
  output logic                       not_empty,
  output logic [cle_pkg::QCNT_W-1:0] count
);

  cle_pkg::cmd_t              slots [cle_pkg::QUEUE_DEPTH];
  logic [cle_pkg::QPTR_W-1:0] wr_ptr;
  logic [cle_pkg::QPTR_W-1:0] rd_ptr;

  assign rd_cmd    = slots[rd_ptr];
  assign not_empty = count != '0;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + cle_pkg::QCNT_W'(wr) - cle_pkg::QCNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

>>> rtl/core/cle_back.sv
module cle_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  cle_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output cle_pkg::out_item_t result
);

  logic               cur_valid;
  cle_pkg::cmd_t      cur;
  logic [1:0]         step;
  logic               out_valid;
  cle_pkg::out_item_t res_next;
  logic [1:0]         step_last;
  logic               advance;
  logic               done;

  // Expand the current command into result items
  always_comb begin
    res_next.out_kind    = cle_pkg::OUT_ECHO;
    res_next.out_byte    = '0;
    res_next.line_length = '0;
    step_last            = 2'd0;
    case (cur.op)
      cle_pkg::OP_ECHO: begin
        res_next.out_byte = cur.data;
      end
      cle_pkg::OP_READ: begin
        res_next.out_kind = cle_pkg::OUT_READ;
        res_next.out_byte = cur.data;
      end
      cle_pkg::OP_LINE_END: begin
        step_last = 2'd1;
        if (step == 2'd0) begin
          res_next.out_byte = cle_pkg::KEY_LF;
        end else begin
          res_next.out_kind    = cle_pkg::OUT_COMPLETE;
          res_next.line_length = cur.len;
        end
      end
      cle_pkg::OP_RUBOUT: begin
        step_last         = 2'd2;
        res_next.out_byte = (step == 2'd1) ? cle_pkg::KEY_SPACE : cle_pkg::KEY_BS;
      end
      cle_pkg::OP_CANCEL: begin
        step_last = 2'd1;
        if (step == 2'd0) begin
          res_next.out_byte = cle_pkg::KEY_LF;
        end else begin
          res_next.out_kind = cle_pkg::OUT_REPRINT;
        end
      end
      cle_pkg::OP_OVERFLOW: begin
        step_last = 2'd3;
        case (step)
          2'd0: res_next.out_byte = cle_pkg::KEY_LF;
          2'd1: res_next.out_kind = cle_pkg::OUT_OVERFLOW;
          2'd2: res_next.out_byte = cle_pkg::KEY_BELL;
          default: res_next.out_kind = cle_pkg::OUT_REPRINT;
        endcase
      end
      default: begin
        res_next.out_byte = cur.data;
      end
    endcase
    res_next.last = step == step_last;
  end

  assign advance = cur_valid && (!out_valid || pop);
  assign done    = advance && res_next.last;
  assign q_pop   = q_not_empty && (!cur_valid || done);
  assign empty   = !out_valid;

  // Advance command, step and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (done) begin
        cur_valid <= 1'b0;
        step      <= '0;
      end else if (advance) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (advance) begin
      result <= res_next;
    end
  end

endmodule
